// ===== rtl/r2t_pkg.sv =====
// shared types, constants and helpers for the radix integer-to-text converter
package r2t_pkg;

	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int RADIX_W     = 5;
	localparam int SYMS_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RADIX   = 16;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_DEPTH = 32;
	localparam int DADDR_W     = $clog2(DIGIT_DEPTH);
	localparam int DCNT_W      = DADDR_W + 1;
	localparam int CHUNK_BITS  = 8;
	localparam int NUM_CHUNKS  = VALUE_W / CHUNK_BITS;
	localparam int CHUNK_W     = $clog2(NUM_CHUNKS);

	localparam int JOB_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIX   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMS_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMS_HI = 2'd2;

	// characters with a fixed meaning
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	// one conversion job from front to back
	typedef struct packed {
		logic               sign_only;
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} r2t_job_t;

	// one output word
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} r2t_word_t;

	// symbol k of the table, symbol 0 in the low byte of lo
	function automatic logic [CHAR_W-1:0] sym_at(input logic [SYMS_W-1:0] lo,
			input logic [SYMS_W-1:0] hi, input logic [DIGIT_W-1:0] k);
		logic [2*SYMS_W-1:0] all;
		all = {hi, lo};
		return all[{k, 3'b000} +: CHAR_W];
	endfunction

endpackage

// ===== rtl/radix_integer_to_text.sv =====
// top level of the radix integer-to-text converter
//
//  channel   direction  handshake          payload
//  input     in         push / full        value (signed 32)
//  result    out        empty / pop        character (8), last
//  config    in         cfg_valid / ready  cfg_index (2), cfg_data (64)
//
// each value passes the combinational front into a job queue slot; the back then
// picks up the job, divides each digit out chunk by chunk (8 quotient bits a cycle
// through the shared divide chunk), emits a minus sign for a negative value, then
// for each digit reads the digit stack and emits its symbol, from the last digit
// down to the first; the stack read port sets the emit rate
// reset is asynchronous and clears both queues and the back sequencer; no clearing
// pass is needed since the digit stack is always written before it is read
// either side may stall: the job queue and the result queue decouple them
module radix_integer_to_text #(
	parameter int JOB_DEPTH = r2t_pkg::JOB_DEPTH_DEF,
	parameter int OUT_DEPTH = r2t_pkg::OUT_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input values
	input  logic                                push,
	output logic                                full,
	input  logic signed [r2t_pkg::VALUE_W-1:0]  value,
	// result characters
	output logic                                empty,
	input  logic                                pop,
	output logic [r2t_pkg::CHAR_W-1:0]          character,
	output logic                                last,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [r2t_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [r2t_pkg::SYMS_W-1:0]          cfg_data
);
	import r2t_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [SYMS_W-1:0]  syms_lo_q;
	logic [SYMS_W-1:0]  syms_hi_q;

	logic      job_push;
	logic      job_pop;
	logic      job_empty;
	r2t_job_t  job_in;
	r2t_job_t  job_out;
	logic      out_push;
	logic      out_full;
	r2t_word_t word_in;
	r2t_word_t word_out;

	// writes are to be issued only while idle, which the block itself does not enforce; the port never holds off
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q   <= '0;
			syms_lo_q <= '0;
			syms_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX:   radix_q   <= cfg_data[RADIX_W-1:0];
				REG_SYMS_LO: syms_lo_q <= cfg_data;
				REG_SYMS_HI: syms_hi_q <= cfg_data;
				default: begin
					// unmapped index, write ignored
				end
			endcase
		end
	end

	// front: classify each value, drop it when the symbol set is unusable or when radix one meets a non-negative value
	r2t_front u_front (
		.in_push  (push),
		.value    (value),
		.radix    (radix_q),
		.syms_lo  (syms_lo_q),
		.syms_hi  (syms_hi_q),
		.job_full (full),
		.job_push (job_push),
		.job      (job_in)
	);

	// jobs waiting for the back end
	r2t_queue #(
		.WIDTH ($bits(r2t_job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	// back: division sequencer, digit stack and character output
	r2t_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radix     (radix_q),
		.syms_lo   (syms_lo_q),
		.syms_hi   (syms_hi_q),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (job_out),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_word  (word_in)
	);

	// result words waiting to be taken
	r2t_queue #(
		.WIDTH ($bits(r2t_word_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (word_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (word_out),
		.empty  (empty)
	);

	assign character = word_out.character;
	assign last      = word_out.last;

endmodule

// ===== rtl/r2t_queue.sv =====
// small first-in first-out queue of words, flop based
module r2t_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/r2t_front.sv =====
// front end: symbol set check, sign and magnitude, job classification
module r2t_front (
	input  logic                          in_push,
	input  logic signed [r2t_pkg::VALUE_W-1:0] value,
	input  logic [r2t_pkg::RADIX_W-1:0]   radix,
	input  logic [r2t_pkg::SYMS_W-1:0]    syms_lo,
	input  logic [r2t_pkg::SYMS_W-1:0]    syms_hi,
	input  logic                          job_full,
	output logic                          job_push,
	output r2t_pkg::r2t_job_t             job
);
	import r2t_pkg::*;

	function automatic logic bad_sym(input logic [CHAR_W-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SPACE) || (c == CH_TAB) ||
			(c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

	// the radix must be 1 to 16, no symbol in use may be a sign or white space, and every pair among them must differ
	function automatic logic set_ok(input logic [RADIX_W-1:0] rdx,
			input logic [SYMS_W-1:0] lo, input logic [SYMS_W-1:0] hi);
		logic ok;
		logic [CHAR_W-1:0] ci;
		ok = (rdx != '0) && (rdx <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < 16; i++) begin
			ci = sym_at(lo, hi, DIGIT_W'(i));
			if (RADIX_W'(i) < rdx) begin
				if (bad_sym(ci)) ok = 1'b0;
				for (int j = i + 1; j < 16; j++) begin
					if (RADIX_W'(j) < rdx && sym_at(lo, hi, DIGIT_W'(j)) == ci) ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	logic               valid_set;
	logic               neg;
	logic [VALUE_W-1:0] raw;
	logic               radix_one;

	assign valid_set = set_ok(radix, syms_lo, syms_hi);
	assign raw       = value;
	assign neg       = raw[VALUE_W-1];
	assign radix_one = (radix == RADIX_W'(1));

	always_comb begin
		job.sign_only = radix_one;
		job.neg       = neg;
		job.mag       = neg ? (VALUE_W'(0) - raw) : raw;
		// radix one with a non-negative value gives nothing at all
		job_push      = in_push && !job_full && valid_set && (!radix_one || neg);
	end

endmodule

// ===== rtl/r2t_back.sv =====
// back end: iterative division into a digit stack, then symbol output
module r2t_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [r2t_pkg::RADIX_W-1:0] radix,
	input  logic [r2t_pkg::SYMS_W-1:0]  syms_lo,
	input  logic [r2t_pkg::SYMS_W-1:0]  syms_hi,
	input  logic                        job_empty,
	output logic                        job_pop,
	input  r2t_pkg::r2t_job_t           job,
	input  logic                        out_full,
	output logic                        out_push,
	output r2t_pkg::r2t_word_t          out_word
);
	import r2t_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	logic [2:0]         state_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [DCNT_W-1:0]  k_q;
	logic               neg_q;
	logic               sign_last_q;
	logic [VALUE_W-1:0] div_q;
	logic [VALUE_W-1:0] quot_q;
	logic [DIGIT_W-1:0] rem_q;

	logic [DIGIT_W-1:0] stack_mem [DIGIT_DEPTH];
	logic [DIGIT_W-1:0] rd_data_q;

	logic [CHUNK_BITS-1:0] qbits;
	logic [DIGIT_W-1:0]    rem_nxt;
	logic [VALUE_W-1:0]    quot_full;
	logic [DCNT_W-1:0]     cnt_inc;
	logic [DCNT_W-1:0]     k_dec;
	logic                  last_chunk;
	logic                  div_done;
	logic                  wr_en;

	// one chunk of long division: eight compare and subtract steps
	always_comb begin
		logic [CHUNK_BITS-1:0] top;
		logic [DIGIT_W:0]      t;
		logic [DIGIT_W-1:0]    r;
		top = div_q[VALUE_W-1 -: CHUNK_BITS];
		r   = rem_q;
		qbits = '0;
		for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
			t = {r, top[b]};
			if (t >= radix) begin
				t        = t - radix;
				qbits[b] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_nxt = r;
	end

	assign quot_full  = {quot_q[VALUE_W-CHUNK_BITS-1:0], qbits};
	assign cnt_inc    = cnt_q + 1'b1;
	assign k_dec      = k_q - 1'b1;
	assign last_chunk = (chunk_q == CHUNK_W'(NUM_CHUNKS - 1));
	assign div_done   = (quot_full == '0) || (cnt_inc == DCNT_W'(DIGIT_DEPTH));
	assign wr_en      = (state_q == ST_DIV) && last_chunk;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign out_push = ((state_q == ST_SIGN) || (state_q == ST_PUSH)) && !out_full;

	always_comb begin
		if (state_q == ST_SIGN) begin
			out_word.character = CH_MINUS;
			out_word.last      = sign_last_q;
		end else begin
			out_word.character = sym_at(syms_lo, syms_hi, rd_data_q);
			out_word.last      = (k_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[cnt_q[DADDR_W-1:0]] <= rem_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_data_q <= stack_mem[k_dec[DADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			neg_q       <= 1'b0;
			sign_last_q <= 1'b0;
			div_q       <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						neg_q   <= job.neg;
						div_q   <= job.mag;
						quot_q  <= '0;
						rem_q   <= '0;
						chunk_q <= '0;
						if (job.sign_only) begin
							sign_last_q <= 1'b1;
							state_q     <= ST_SIGN;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 1'b1;
					if (last_chunk) begin
						cnt_q  <= cnt_inc;
						div_q  <= quot_full;
						quot_q <= '0;
						rem_q  <= '0;
						if (div_done) begin
							k_q         <= cnt_inc;
							sign_last_q <= 1'b0;
							state_q     <= neg_q ? ST_SIGN : ST_READ;
						end
					end else begin
						div_q  <= {div_q[VALUE_W-CHUNK_BITS-1:0], CHUNK_BITS'(0)};
						quot_q <= quot_full;
						rem_q  <= rem_nxt;
					end
				end
				ST_SIGN: begin
					if (!out_full) begin
						state_q <= sign_last_q ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: begin
					k_q     <= k_dec;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_full) begin
						state_q <= (k_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/r2t_checker.sv =====
// port-level checks for the radix integer-to-text converter, with its bind
module r2t_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               push,
	input logic                               full,
	input logic signed [r2t_pkg::VALUE_W-1:0] value,
	input logic                               empty,
	input logic                               pop,
	input logic [r2t_pkg::CHAR_W-1:0]         character,
	input logic                               last,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [r2t_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [r2t_pkg::SYMS_W-1:0]         cfg_data
);
	import r2t_pkg::*;

	// set while the words of one value are part way out
	logic mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (pop && !empty) begin
			mid_q <= !last;
		end
	end

	// nothing to take while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

	// a waiting word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(character) && $stable(last)))
		else $error("waiting result word changed");

	// a minus sign only ever opens a value
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mid_q) |-> (character != CH_MINUS))
		else $error("minus sign inside a value");

	// input side is free straight out of reset
	a_not_full_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> !full)
		else $error("input full straight after reset");

endmodule

bind radix_integer_to_text r2t_checker u_r2t_checker (.*);
